// ===== rtl/bmprgb_pkg.sv =====
// shared types, constants and helpers for the bmp pixel stream to rgb565 converter
package bmprgb_pkg;

  localparam int unsigned MAX_IMAGE_WIDTH = 4095;

  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned STRIDE_W = 14;
  localparam int unsigned SCALE_W  = 17;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = COORD_W + SCALE_W + 1;

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(32768);

  // register indexes of the configuration port
  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_X_SCALE     = 2'd1;
  localparam logic [1:0] CFG_Y_SCALE     = 2'd2;

  localparam logic [COLOR_W-1:0] GREEN_MASK = 16'h07E0;
  localparam logic [COLOR_W-1:0] RED_MASK   = 16'hF800;

  // which byte of the bgr triple comes next
  typedef enum logic [2:0] {
    COMP_BLUE  = 3'b001,
    COMP_GREEN = 3'b010,
    COMP_RED   = 3'b100
  } comp_t;

  function automatic logic [WIDTH_W-1:0] sat_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] lim;
    lim = WIDTH_W'(MAX_IMAGE_WIDTH);
    sat_width = (w > lim) ? lim : w;
  endfunction

  // row stride in bytes: 3*w rounded up to a multiple of four
  function automatic logic [STRIDE_W-1:0] row_stride(input logic [WIDTH_W-1:0] w);
    logic [STRIDE_W-1:0] sum;
    sum = {1'b0, w, 1'b0} + STRIDE_W'(w) + STRIDE_W'(3);
    row_stride = {sum[STRIDE_W-1:2], 2'b00};
  endfunction

endpackage

// ===== rtl/bmprgb_coord_scale.sv =====
// scales one pixel coordinate by a q1.16 ratio with round half up
module bmprgb_coord_scale import bmprgb_pkg::*; (
  input  logic [COORD_W-1:0] pos,
  input  logic [SCALE_W-1:0] ratio,
  output logic [COORD_W-1:0] coord
);

  logic [PROD_W-1:0] prod;

  assign prod  = (PROD_W'(pos) * PROD_W'(ratio)) + ROUND_HALF;
  assign coord = prod[FRAC_W +: COORD_W];

endmodule

// ===== rtl/bmp_pixel_stream_to_rgb565.sv =====
// bmp 24-bit pixel byte stream to rgb565 pixels with scaled screen coordinates
// flow: a pixel is loaded into the pixel register at the edge that takes its red byte
//   and then into the output register, which drives out_tvalid
// throughput: one byte per cycle unless the output stalls; combinational byte assembly and row counters
// reset: synchronous, active low; counters clear, width 1, both scales 1.0
// in_tuser high on a byte clears all counters before that byte is used
module bmp_pixel_stream_to_rgb565 import bmprgb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // data_byte[7:0]
  input  logic                in_tuser,   // image_start
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // pixel_color[15:0], screen_x[27:16], screen_y[39:28]
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [SCALE_W-1:0]  cfg_wdata
);

  logic [WIDTH_W-1:0]  width_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [SCALE_W-1:0]  x_scale_r;
  logic [SCALE_W-1:0]  y_scale_r;

  comp_t               comp_r, comp_nxt;
  logic [COLOR_W-1:0]  pc_r, pc_nxt;
  logic [COORD_W-1:0]  col_r, col_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt;
  logic [STRIDE_W-1:0] rbc_r, rbc_nxt;

  logic                pix_valid_r;
  logic [COLOR_W-1:0]  pix_color_r, pix_color_nxt;
  logic [COORD_W-1:0]  pix_col_r;
  logic [COORD_W-1:0]  pix_row_r;
  logic                emit;

  logic                out_valid_r;
  logic [39:0]         out_data_r;
  logic [COORD_W-1:0]  sx, sy;

  logic in_accept;
  logic out_load;
  logic pix_load;

  assign out_load  = !out_valid_r || out_tready;
  assign pix_load  = !pix_valid_r || out_load;
  assign in_tready = pix_load;
  assign in_accept = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_W'(1);
      stride_r  <= row_stride(WIDTH_W'(1));
      x_scale_r <= SCALE_ONE;
      y_scale_r <= SCALE_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          width_r  <= sat_width(cfg_wdata[WIDTH_W-1:0]);
          stride_r <= row_stride(sat_width(cfg_wdata[WIDTH_W-1:0]));
        end
        CFG_X_SCALE: x_scale_r <= cfg_wdata;
        CFG_Y_SCALE: y_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // byte assembly and row tracking
  always_comb begin
    comp_t               comp0;
    logic [COLOR_W-1:0]  pc0;
    logic [COORD_W-1:0]  col0;
    logic [COORD_W-1:0]  row0;
    logic [STRIDE_W-1:0] rbc0;

    comp0 = in_tuser ? COMP_BLUE : comp_r;
    pc0   = in_tuser ? '0 : pc_r;
    col0  = in_tuser ? '0 : col_r;
    row0  = in_tuser ? '0 : row_r;
    rbc0  = in_tuser ? '0 : rbc_r;

    comp_nxt      = comp0;
    pc_nxt        = pc0;
    col_nxt       = col0;
    row_nxt       = row0;
    emit          = 1'b0;
    pix_color_nxt = pc0 | ({in_tdata, 8'b0} & RED_MASK);

    // padding bytes past the last pixel only count toward the stride
    if (col0 < width_r) begin
      unique case (comp0)
        COMP_GREEN: begin
          pc_nxt   = pc0 | ({5'b0, in_tdata, 3'b0} & GREEN_MASK);
          comp_nxt = COMP_RED;
        end
        COMP_RED: begin
          emit     = 1'b1;
          pc_nxt   = '0;
          comp_nxt = COMP_BLUE;
          col_nxt  = col0 + COORD_W'(1);
        end
        default: begin
          pc_nxt   = {11'b0, in_tdata[7:3]};
          comp_nxt = COMP_GREEN;
        end
      endcase
    end

    rbc_nxt = rbc0 + STRIDE_W'(1);
    if (rbc_nxt >= stride_r) begin
      rbc_nxt  = '0;
      col_nxt  = '0;
      comp_nxt = COMP_BLUE;
      pc_nxt   = '0;
      row_nxt  = row0 + COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_r <= COMP_BLUE;
      pc_r   <= '0;
      col_r  <= '0;
      row_r  <= '0;
      rbc_r  <= '0;
    end else if (in_accept) begin
      comp_r <= comp_nxt;
      pc_r   <= pc_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      rbc_r  <= rbc_nxt;
    end
  end

  // pixel register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (pix_load) begin
      pix_valid_r <= in_accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_load) begin
      pix_color_r <= pix_color_nxt;
      pix_col_r   <= in_tuser ? '0 : col_r;
      pix_row_r   <= in_tuser ? '0 : row_r;
    end
  end

  bmprgb_coord_scale u_scale_x (
    .pos   (pix_col_r),
    .ratio (x_scale_r),
    .coord (sx)
  );

  bmprgb_coord_scale u_scale_y (
    .pos   (pix_row_r),
    .ratio (y_scale_r),
    .coord (sy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= pix_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {sy, sx, pix_color_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a stalled pixel keeps its contents until the output register takes it
  a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pix_valid_r && !out_load |=> pix_valid_r && $stable(pix_color_r)
      && $stable(pix_col_r) && $stable(pix_row_r))
    else $error("pixel register changed while stalled");

  // an empty pixel register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !pix_valid_r |-> in_tready)
    else $error("input stalled with empty pixel register");

  // a finished pixel restarts assembly at blue
  a_emit_blue: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && emit |=> comp_r == COMP_BLUE)
    else $error("component not back at blue after a pixel");

  // nothing gathered while waiting for a blue byte
  a_blue_empty: assert property (@(posedge clk) disable iff (!rst_n)
    comp_r == COMP_BLUE |-> pc_r == '0)
    else $error("partial color not clear at blue");

endmodule
